FILE: hdl/jrbi_pkg.sv
// ----------------------------------------------------------------------------
// jrbi_pkg: shared definitions for the bounded random integer generator
// Constants of the 48-bit LCG, operation codes and the control/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package jrbi_pkg;

  localparam int SEED_W  = 48;
  localparam int MULT_W  = 35;
  localparam int DRAW_W  = 31;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 6;
  localparam int OP_W    = 2;

  localparam logic [MULT_W-1:0] LCG_MULT = 35'h5DEECE66D;
  localparam logic [SEED_W-1:0] LCG_ADD  = 48'd11;

  localparam logic [OP_W-1:0] OP_SET_SEED = 2'd0;
  localparam logic [OP_W-1:0] OP_NEXT_BITS = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT_INT = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic load;       // latch request fields
    logic decode;     // clear value, set error flag
    logic seed_set;   // load seed from request
    logic mul_step;   // one partial product of the seed update
    logic div_step;   // one remainder bit
    logic val_bits;   // value from top seed bits
    logic val_pow;    // value from power-of-two multiply
    logic val_rem;    // value from remainder
    logic out_load;   // load result registers
  } jrbi_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bound_bad;
    logic            bound_pow2;
    logic            mul_last;
    logic            div_last;
    logic            reject;
  } jrbi_status_t;

endpackage

FILE: hdl/jrbi_ctrl.sv
// ----------------------------------------------------------------------------
// jrbi_ctrl: operation sequencer
// Walks each request through decode, seed update, draw and remainder
// steps, retries rejected draws and owns both handshakes.
// ----------------------------------------------------------------------------
module jrbi_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  jrbi_pkg::jrbi_status_t status,
  output jrbi_pkg::jrbi_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_BITS  = 3'd3;
  localparam logic [2:0] S_POW   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       rsp_valid_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        unique case (status.op)
          jrbi_pkg::OP_SET_SEED: begin
            cmd.seed_set = 1'b1;
            state_next = S_FIN;
          end
          jrbi_pkg::OP_NEXT_BITS: state_next = S_MUL;
          jrbi_pkg::OP_NEXT_INT: state_next = status.bound_bad ? S_FIN : S_MUL;
          default: state_next = S_FIN;
        endcase
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          if (status.op == jrbi_pkg::OP_NEXT_BITS) begin
            state_next = S_BITS;
          end else if (status.bound_pow2) begin
            state_next = S_POW;
          end else begin
            state_next = S_DIV;
          end
        end
      end
      S_BITS: begin
        cmd.val_bits = 1'b1;
        state_next = S_FIN;
      end
      S_POW: begin
        cmd.val_pow = 1'b1;
        state_next = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // draw again on rejection; the seed has already advanced
        if (status.reject) begin
          state_next = S_MUL;
        end else begin
          cmd.val_rem = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_stall) begin
      rsp_valid_next = rsp_valid;
    end else begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

FILE: hdl/jrbi_dp.sv
// ----------------------------------------------------------------------------
// jrbi_dp: seed register and arithmetic
// Seed update by three 16-bit partial products, a restoring remainder
// unit one bit per cycle, the power-of-two multiply and result registers.
// ----------------------------------------------------------------------------
module jrbi_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [jrbi_pkg::OP_W-1:0]      op,
  input  logic [jrbi_pkg::SEED_W-1:0]    seed_in,
  input  logic                           scramble,
  input  logic [jrbi_pkg::CNT_W-1:0]     bit_count,
  input  logic signed [31:0]             bound,
  input  jrbi_pkg::jrbi_cmd_t            cmd,
  output jrbi_pkg::jrbi_status_t         status,
  output logic [jrbi_pkg::VALUE_W-1:0]   value,
  output logic [jrbi_pkg::SEED_W-1:0]    seed_out,
  output logic                           error
);

  localparam logic [1:0] MUL_LAST = 2'd2;
  localparam logic [4:0] DIV_LAST = 5'd30;

  logic [jrbi_pkg::SEED_W-1:0]  seed;
  logic [jrbi_pkg::OP_W-1:0]    op_q;
  logic [jrbi_pkg::SEED_W-1:0]  seed_in_q;
  logic                         scr_q;
  logic [jrbi_pkg::CNT_W-1:0]   cnt_q;
  logic [31:0]                  bound_q;
  logic [jrbi_pkg::SEED_W-1:0]  acc;
  logic [1:0]                   k;
  logic [jrbi_pkg::DRAW_W-1:0]  r;
  logic [jrbi_pkg::DRAW_W-1:0]  dq;
  logic [jrbi_pkg::DRAW_W-1:0]  rem;
  logic [4:0]                   dcnt;
  logic [jrbi_pkg::VALUE_W-1:0] val;
  logic                         err;

  logic [15:0]                  chunk;
  logic [50:0]                  pp;
  logic [jrbi_pkg::SEED_W-1:0]  pp_sh;
  logic [jrbi_pkg::SEED_W-1:0]  mul_sum;
  logic [jrbi_pkg::SEED_W-1:0]  new_seed;
  logic [jrbi_pkg::SEED_W-1:0]  set_val;
  logic [31:0]                  trial;
  logic [31:0]                  divisor;
  logic                         ge;
  logic [31:0]                  t;
  logic [61:0]                  pow_prod;
  logic [jrbi_pkg::CNT_W-1:0]   cnt_sat;
  logic [6:0]                   sh;
  logic [jrbi_pkg::SEED_W-1:0]  bits_sh;

  // seed * multiplier mod 2^48, one 16-bit slice of the seed per cycle
  assign chunk    = seed[{k, 4'b0000} +: 16];
  assign pp       = {35'd0, chunk} * {16'd0, jrbi_pkg::LCG_MULT};
  assign pp_sh    = pp[47:0] << {k, 4'b0000};
  assign mul_sum  = acc + pp_sh;
  assign new_seed = mul_sum + jrbi_pkg::LCG_ADD;

  assign set_val = seed_in_q ^ (scr_q ? {13'd0, jrbi_pkg::LCG_MULT} : '0);

  assign divisor = {1'b0, bound_q[30:0]};
  assign trial   = {rem, dq[30]};
  assign ge      = (trial >= divisor);

  // rejection test wraps in 32 bits
  assign t = {1'b0, r} - {1'b0, rem} + bound_q - 32'd1;

  assign pow_prod = {31'd0, bound_q[30:0]} * {31'd0, r};

  assign cnt_sat = (cnt_q > 6'd32) ? 6'd32 : cnt_q;
  assign sh      = 7'd48 - {1'b0, cnt_sat};
  assign bits_sh = seed >> sh;

  assign status.op         = op_q;
  assign status.bound_bad  = (bound_q == 32'd0) || bound_q[31];
  assign status.bound_pow2 = ((bound_q & (~bound_q + 32'd1)) == bound_q);
  assign status.mul_last   = (k == MUL_LAST);
  assign status.div_last   = (dcnt == DIV_LAST);
  assign status.reject     = t[31];

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
      acc <= '0;
      k <= '0;
      dcnt <= '0;
    end else begin
      if (cmd.seed_set && op_q == jrbi_pkg::OP_SET_SEED) begin
        seed <= set_val;
      end
      if (cmd.mul_step) begin
        if (k == MUL_LAST) begin
          seed <= new_seed;
          acc <= '0;
          k <= '0;
          dcnt <= '0;
        end else begin
          acc <= mul_sum;
          k <= k + 2'd1;
        end
      end
      if (cmd.div_step) begin
        dcnt <= dcnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= op;
      seed_in_q <= seed_in;
      scr_q <= scramble;
      cnt_q <= bit_count;
      bound_q <= bound;
    end
    if (cmd.mul_step && k == MUL_LAST) begin
      r <= new_seed[47:17];
      dq <= new_seed[47:17];
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? 31'(trial - divisor) : trial[30:0];
      dq <= {dq[29:0], 1'b0};
    end
    if (cmd.decode) begin
      val <= '0;
      err <= (op_q == jrbi_pkg::OP_NEXT_INT) && status.bound_bad;
    end
    if (cmd.val_bits) begin
      val <= bits_sh[31:0];
    end
    if (cmd.val_pow) begin
      val <= {1'b0, pow_prod[61:31]};
    end
    if (cmd.val_rem) begin
      val <= {1'b0, rem};
    end
    if (cmd.out_load) begin
      value <= val;
      seed_out <= seed;
      error <= err;
    end
  end

endmodule

FILE: hdl/java_random_bounded_int.sv
// Steps: set seed, error and unused op go from decode straight to output load;
// next bits and power-of-two bound add the seed multiply and a value step; other
// bounds run decode, seed multiply, remainder unit, check and output load for one draw,
// and repeat seed multiply, remainder unit and check for each rejected draw.
// Throughput: one request at a time; a new request is taken while a result waits.
// Reset (synchronous, active high) clears the seed to zero and empties the result stage.
// ----------------------------------------------------------------------------
// java_random_bounded_int: 48-bit LCG random number generator
// Set seed, next bits and next bounded int operations with one result
// per request, built as a sequencer and a datapath.
// ----------------------------------------------------------------------------
module java_random_bounded_int (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [jrbi_pkg::OP_W-1:0]    op,
  input  logic [jrbi_pkg::SEED_W-1:0]  seed_in,
  input  logic                         scramble,
  input  logic [jrbi_pkg::CNT_W-1:0]   bit_count,
  input  logic signed [31:0]           bound,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [jrbi_pkg::VALUE_W-1:0] value,
  output logic [jrbi_pkg::SEED_W-1:0]  seed_out,
  output logic                         error
);

  jrbi_pkg::jrbi_cmd_t    cmd;
  jrbi_pkg::jrbi_status_t status;

  jrbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  jrbi_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .seed_in   (seed_in),
    .scramble  (scramble),
    .bit_count (bit_count),
    .bound     (bound),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .seed_out  (seed_out),
    .error     (error)
  );

endmodule

FILE: hdl/jrbi_checker.sv
// ----------------------------------------------------------------------------
// jrbi_checker: port-level assertions
// Watches the request and result handshakes of the generator.
// ----------------------------------------------------------------------------
module jrbi_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_stall,
  input logic                         rsp_valid,
  input logic                         rsp_stall,
  input logic [jrbi_pkg::VALUE_W-1:0] value,
  input logic                         error
);

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error |-> value == '0)
    else $error("error result carries a nonzero value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while one is in work");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind java_random_bounded_int jrbi_checker u_jrbi_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .value     (value),
  .error     (error)
);

FILE: tb/java_random_bounded_int_tb.sv
// ----------------------------------------------------------------------------
// java_random_bounded_int_tb: self-checking bench for the 48-bit LCG block
// Drives set seed, next bits and next bounded int requests, predicts every
// result with a local copy of the generator state and checks value, seed and
// error flag in order, under random idle bursts and a long output hold.
// ----------------------------------------------------------------------------
module java_random_bounded_int_tb;

  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [jrbi_pkg::VALUE_W-1:0] value;
    logic [jrbi_pkg::SEED_W-1:0]  seed;
    logic                         error;
  } rng_result_t;

  logic                          clk;
  logic                          rst;
  logic                          req_valid;
  logic                          req_stall;
  logic [jrbi_pkg::OP_W-1:0]     op;
  logic [jrbi_pkg::SEED_W-1:0]   seed_in;
  logic                          scramble;
  logic [jrbi_pkg::CNT_W-1:0]    bit_count;
  logic signed [31:0]            bound;
  logic                          rsp_valid;
  logic                          rsp_stall;
  logic [jrbi_pkg::VALUE_W-1:0]  value;
  logic [jrbi_pkg::SEED_W-1:0]   seed_out;
  logic                          error;

  rng_result_t pending_results[$];
  rng_result_t want;
  logic [jrbi_pkg::SEED_W-1:0] seed_model;
  int errors = 0;
  bit quiet = 0;
  bit hold_long = 0;

  java_random_bounded_int dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .op(op), .seed_in(seed_in), .scramble(scramble),
    .bit_count(bit_count), .bound(bound),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .value(value), .seed_out(seed_out), .error(error)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2400000;
    $display("java_random_bounded_int_tb failed");
    $finish;
  end

  // Advance the generator once and return its top cnt bits (cnt saturates at 32).
  function automatic logic [31:0] draw_top(input int unsigned cnt);
    logic [63:0] prod;
    logic [63:0] shifted;
    prod = {16'b0, seed_model} * 64'(jrbi_pkg::LCG_MULT) + 64'(jrbi_pkg::LCG_ADD);
    seed_model = prod[jrbi_pkg::SEED_W-1:0];
    if (cnt > 32) cnt = 32;
    shifted = {16'b0, seed_model} >> (48 - cnt);
    return shifted[31:0];
  endfunction

  function automatic rng_result_t predict_result(
      input logic [jrbi_pkg::OP_W-1:0]   op_i,
      input logic [jrbi_pkg::SEED_W-1:0] seed_i,
      input logic                        scr_i,
      input logic [jrbi_pkg::CNT_W-1:0]  cnt_i,
      input logic [31:0]                 bound_i);
    rng_result_t r;
    logic [31:0] draw;
    logic [31:0] rem;
    logic [31:0] lim;
    logic [63:0] wide;
    r.value = '0;
    r.error = 1'b0;
    case (op_i)
      jrbi_pkg::OP_SET_SEED: begin
        seed_model = scr_i ? (seed_i ^ {13'b0, jrbi_pkg::LCG_MULT}) : seed_i;
      end
      jrbi_pkg::OP_NEXT_BITS: begin
        r.value = draw_top(cnt_i);
      end
      jrbi_pkg::OP_NEXT_INT: begin
        if (bound_i == 0 || bound_i[31]) begin
          r.error = 1'b1;
        end else if ((bound_i & (32'd0 - bound_i)) == bound_i) begin
          draw = draw_top(31);
          wide = 64'(bound_i) * 64'(draw);
          r.value = wide[62:31];
        end else begin
          // retry while the 32-bit wrapped limit goes negative
          do begin
            draw = draw_top(31);
            rem = draw % bound_i;
            lim = draw - rem + (bound_i - 32'd1);
          end while (lim[31]);
          r.value = rem;
        end
      end
      default: ;
    endcase
    r.seed = seed_model;
    return r;
  endfunction

  function automatic logic [jrbi_pkg::SEED_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[jrbi_pkg::SEED_W-1:0];
  endfunction

  function automatic logic [jrbi_pkg::CNT_W-1:0] rand_count();
    return ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(1, 32));
  endfunction

  function automatic logic [31:0] rand_bound();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(1, 100);
      2: return 32'd1 << $urandom_range(0, 30);
      3: return ($urandom_range(0, 1) == 0) ? 32'd0 - $urandom_range(0, 1000)
                                            : (32'h80000000 | $urandom());
      4: return 32'h40000000 + $urandom_range(1, 1000);
      default: return $urandom() & 32'h7FFFFFFF;
    endcase
  endfunction

  // Offer one request, hold it until taken, then record its prediction.
  task automatic send_req(input logic [jrbi_pkg::OP_W-1:0]   op_i,
                          input logic [jrbi_pkg::SEED_W-1:0] seed_i,
                          input logic                        scr_i,
                          input logic [jrbi_pkg::CNT_W-1:0]  cnt_i,
                          input logic [31:0]                 bound_i);
    req_valid <= 1'b1;
    op        <= op_i;
    seed_in   <= seed_i;
    scramble  <= scr_i;
    bit_count <= cnt_i;
    bound     <= bound_i;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(predict_result(op_i, seed_i, scr_i, cnt_i, bound_i));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_random(input logic [jrbi_pkg::OP_W-1:0] op_i);
    send_req(op_i, rand48(), 1'($urandom_range(0, 1)), rand_count(), rand_bound());
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_seed_load();
    send_req(jrbi_pkg::OP_SET_SEED, '0, 1'b0, rand_count(), rand_bound());
    send_req(jrbi_pkg::OP_NEXT_BITS, rand48(), 1'b1, 6'd32, rand_bound());
    send_req(jrbi_pkg::OP_SET_SEED, '1, 1'b0, rand_count(), rand_bound());
    send_req(jrbi_pkg::OP_SET_SEED, '1, 1'b1, rand_count(), rand_bound());
    send_req(jrbi_pkg::OP_SET_SEED, '0, 1'b1, rand_count(), rand_bound());
    drain();
  endtask

  task automatic test_next_bits();
    send_req(jrbi_pkg::OP_NEXT_BITS, rand48(), 1'b0, 6'd0, rand_bound());
    send_req(jrbi_pkg::OP_NEXT_BITS, rand48(), 1'b1, 6'd1, rand_bound());
    send_req(jrbi_pkg::OP_NEXT_BITS, rand48(), 1'b0, 6'd31, rand_bound());
    send_req(jrbi_pkg::OP_NEXT_BITS, rand48(), 1'b1, 6'd32, rand_bound());
    send_req(jrbi_pkg::OP_NEXT_BITS, rand48(), 1'b0, 6'd33, rand_bound());
    send_req(jrbi_pkg::OP_NEXT_BITS, rand48(), 1'b1, 6'd63, rand_bound());
    drain();
  endtask

  task automatic test_bounded_pow2();
    send_req(jrbi_pkg::OP_NEXT_INT, rand48(), 1'b0, rand_count(), 32'd1);
    send_req(jrbi_pkg::OP_NEXT_INT, rand48(), 1'b1, rand_count(), 32'd2);
    send_req(jrbi_pkg::OP_NEXT_INT, rand48(), 1'b0, rand_count(), 32'h40000000);
    drain();
  endtask

  task automatic test_bounded_reject();
    send_req(jrbi_pkg::OP_NEXT_INT, rand48(), 1'b0, rand_count(), 32'd3);
    send_req(jrbi_pkg::OP_NEXT_INT, rand48(), 1'b1, rand_count(), 32'd7);
    // just above 2^30: about half of all draws are thrown away
    send_req(jrbi_pkg::OP_NEXT_INT, rand48(), 1'b0, rand_count(), 32'h40000001);
    send_req(jrbi_pkg::OP_NEXT_INT, rand48(), 1'b1, rand_count(), 32'h7FFFFFFF);
    send_req(jrbi_pkg::OP_NEXT_INT, rand48(), 1'b0, rand_count(), 32'd1000000007);
    drain();
  endtask

  task automatic test_bad_bound_and_nop();
    send_req(jrbi_pkg::OP_NEXT_INT, rand48(), 1'b0, rand_count(), 32'd0);
    send_req(jrbi_pkg::OP_NEXT_INT, rand48(), 1'b1, rand_count(), 32'hFFFFFFFF);
    send_req(jrbi_pkg::OP_NEXT_INT, rand48(), 1'b0, rand_count(), 32'h80000000);
    send_req(jrbi_pkg::OP_NOP, rand48(), 1'b1, rand_count(), rand_bound());
    drain();
  endtask

  // Hold the output side for a long stretch so the block backs up its input.
  task automatic test_backpressure();
    hold_long = 1'b1;
    repeat (16) send_random(2'($urandom_range(0, 3)));
    drain();
  endtask

  // Mostly reseed followed by a run of draws, the rest single random requests.
  task automatic test_random_mix(input int n_items);
    int sent;
    int run;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        send_random(jrbi_pkg::OP_SET_SEED);
        run = $urandom_range(1, 12);
        repeat (run) send_random($urandom_range(0, 2) == 0 ? jrbi_pkg::OP_NEXT_BITS
                                                           : jrbi_pkg::OP_NEXT_INT);
        sent += run + 1;
      end else begin
        send_random(2'($urandom_range(0, 3)));
        sent++;
      end
    end
    drain();
  endtask

  // Output side: random stall bursts, free stretches, and one long hold on request.
  initial begin
    rsp_stall <= 1'b0;
    repeat (4) @(posedge clk);
    forever begin
      if (hold_long) begin
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        repeat (quiet ? 1 : $urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: value %h seed %h error %b",
                 $time, value, seed_out, error);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (value !== want.value) begin
          $display("%0t: value mismatch: expected %h, got %h", $time, want.value, value);
          errors++;
        end
        if (seed_out !== want.seed) begin
          $display("%0t: seed_out mismatch: expected %h, got %h", $time, want.seed, seed_out);
          errors++;
        end
        if (error !== want.error) begin
          $display("%0t: error mismatch: expected %b, got %b", $time, want.error, error);
          errors++;
        end
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    op        <= jrbi_pkg::OP_NOP;
    seed_in   <= '0;
    scramble  <= 1'b0;
    bit_count <= '0;
    bound     <= '0;
    seed_model = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_seed_load();
    test_next_bits();
    test_bounded_pow2();
    test_bounded_reject();
    test_bad_bound_and_nop();
    test_backpressure();
    test_random_mix(600);
    quiet = 1'b1;
    test_random_mix(80);
    if (errors == 0) begin
      $display("java_random_bounded_int_tb passed");
    end else begin
      $display("java_random_bounded_int_tb failed");
    end
    $finish;
  end

endmodule
